/* rtl/mlrf_pkg.sv */
// ----------------------------------------------------------------------------
// mlrf_pkg
// Shared types and constants of the memory LCD row update framer.
// ----------------------------------------------------------------------------
package mlrf_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_ROW   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] CMD_WRITE  = 8'h01;
  localparam logic [7:0] CMD_CLEAR  = 8'h04;
  localparam logic [7:0] DUMMY_BYTE = 8'h00;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_ADDR,
    ST_DATA,
    ST_DUMMY,
    ST_TAIL,
    ST_CLR_CMD,
    ST_CLR_END,
    ST_ERR
  } mlrf_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       eot;
    logic       bad;
  } mlrf_emit_t;

endpackage

/* rtl/memory_lcd_row_update_framer.sv */
// ----------------------------------------------------------------------------
// memory_lcd_row_update_framer
// Frame store and byte stream framer for the multiple line write of a
// memory LCD.
//
//   Channel  Direction  Ports
//   in_      input      in_valid, in_ready, in_op, in_store_address,
//                       in_store_data, in_gate_line, in_final_row
//   out_     output     out_valid, out_ready, out_byte,
//                       out_end_of_transfer, out_bad_request
//
// Requests and frame byte writes are taken only while the sequencer is idle.
// A row streams LINE_BYTES + 2 bytes inside a burst, one more for the write
// command that opens a burst and one more for the closing dummy of the final
// row. A clear sends the clear command and a closing dummy, a bad row one
// byte flagged bad. The output register moves one byte per cycle unless
// stalled. Reset clears the sequencer and burst state; the frame store holds
// no defined value until written. A stalled output holds the sequencer in place.
// ----------------------------------------------------------------------------
module memory_lcd_row_update_framer
  import mlrf_pkg::*;
#(
  parameter int LINES      = 168,
  parameter int LINE_BYTES = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [11:0] in_store_address,
  input  logic [7:0]  in_store_data,
  input  logic [7:0]  in_gate_line,
  input  logic        in_final_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_end_of_transfer,
  output logic        out_bad_request
);

  localparam int STORE_DEPTH = LINES * LINE_BYTES;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  mlrf_emit_t    emit;
  logic          slot_free;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          valid_r, valid_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          eot_r, eot_nxt;
  logic          bad_r, bad_nxt;

  mlrf_ctrl #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES),
    .AW         (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_store_address (in_store_address),
    .in_store_data    (in_store_data),
    .in_gate_line     (in_gate_line),
    .in_final_row     (in_final_row),
    .slot_free        (slot_free),
    .emit             (emit),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  mlrf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    eot_nxt   = eot_r;
    bad_nxt   = bad_r;
    if (slot_free) begin
      valid_nxt = emit.valid;
      byte_nxt  = emit.data;
      eot_nxt   = emit.eot;
      bad_nxt   = emit.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
    eot_r  <= eot_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_valid           = valid_r;
  assign out_byte            = byte_r;
  assign out_end_of_transfer = eot_r;
  assign out_bad_request     = bad_r;

endmodule

/* rtl/mlrf_ram.sv */
// ----------------------------------------------------------------------------
// mlrf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mlrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mlrf_ctrl.sv */
// ----------------------------------------------------------------------------
// mlrf_ctrl
// Request decoder and byte sequencer. Writes the frame store, tracks the
// open burst and walks one row of the store to build the update stream.
// ----------------------------------------------------------------------------
module mlrf_ctrl
  import mlrf_pkg::*;
#(
  parameter int LINES      = 168,
  parameter int LINE_BYTES = 18,
  parameter int AW         = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_op,
  input  logic [11:0]   in_store_address,
  input  logic [7:0]    in_store_data,
  input  logic [7:0]    in_gate_line,
  input  logic          in_final_row,
  input  logic          slot_free,
  output mlrf_emit_t    emit,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata
);

  localparam int STORE_DEPTH = LINES * LINE_BYTES;
  localparam int CW          = $clog2(LINE_BYTES + 1);

  mlrf_state_t   state_r, state_nxt;
  logic          open_r, open_nxt;
  logic [7:0]    rows_r, rows_nxt;
  logic [7:0]    line_r, line_nxt;
  logic          final_r, final_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;

  logic          accept;
  logic          row_bad;
  logic          last_col;
  logic [AW-1:0] row_base;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign row_bad  = (in_gate_line == 8'd0) || (in_gate_line > 8'(LINES)) ||
                    (rows_r >= 8'(LINES));
  assign last_col = (col_r == CW'(LINE_BYTES - 1));
  assign row_base = AW'(32'(in_gate_line - 8'd1) * 32'(LINE_BYTES));

  assign ram_we    = accept && (in_op == OP_WRITE) &&
                     (32'(in_store_address) < 32'(STORE_DEPTH));
  assign ram_waddr = AW'(in_store_address);
  assign ram_wdata = in_store_data;
  assign ram_raddr = rd_addr_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_ROW) begin
            if (row_bad) begin
              state_nxt = ST_ERR;
            end else if (open_r) begin
              state_nxt = ST_ADDR;
            end else begin
              state_nxt = ST_CMD;
            end
          end else if (in_op == OP_CLEAR) begin
            state_nxt = ST_CLR_CMD;
          end
        end
      end
      ST_CMD:     if (slot_free) state_nxt = ST_ADDR;
      ST_ADDR:    if (slot_free) state_nxt = ST_DATA;
      ST_DATA:    if (slot_free && last_col) state_nxt = ST_DUMMY;
      ST_DUMMY:   if (slot_free) state_nxt = final_r ? ST_TAIL : ST_IDLE;
      ST_TAIL:    if (slot_free) state_nxt = ST_IDLE;
      ST_CLR_CMD: if (slot_free) state_nxt = ST_CLR_END;
      ST_CLR_END: if (slot_free) state_nxt = ST_IDLE;
      ST_ERR:     if (slot_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    emit = '{valid: 1'b1, data: DUMMY_BYTE, eot: 1'b0, bad: 1'b0};
    unique case (state_r)
      ST_IDLE:    emit.valid = 1'b0;
      ST_CMD:     emit.data = CMD_WRITE;
      ST_ADDR:    emit.data = line_r;
      ST_DATA:    emit.data = ram_rdata;
      ST_DUMMY:   emit.data = DUMMY_BYTE;
      ST_TAIL:    emit.eot = 1'b1;
      ST_CLR_CMD: emit.data = CMD_CLEAR;
      ST_CLR_END: emit.eot = 1'b1;
      ST_ERR: begin
        emit.eot = 1'b1;
        emit.bad = 1'b1;
      end
      default:    emit.valid = 1'b0;
    endcase
  end

  always_comb begin
    open_nxt    = open_r;
    rows_nxt    = rows_r;
    line_nxt    = line_r;
    final_nxt   = final_r;
    col_nxt     = col_r;
    rd_addr_nxt = rd_addr_r;
    if (accept && (in_op == OP_ROW)) begin
      line_nxt    = in_gate_line;
      final_nxt   = in_final_row;
      col_nxt     = '0;
      rd_addr_nxt = row_base;
      if (row_bad || in_final_row) begin
        open_nxt = 1'b0;
        rows_nxt = '0;
      end else begin
        open_nxt = 1'b1;
        rows_nxt = (open_r ? rows_r : 8'd0) + 8'd1;
      end
    end else if (accept && (in_op == OP_CLEAR)) begin
      open_nxt = 1'b0;
      rows_nxt = '0;
    end else if ((state_r == ST_DATA) && slot_free) begin
      col_nxt     = col_r + CW'(1);
      rd_addr_nxt = rd_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      open_r  <= 1'b0;
      rows_r  <= '0;
    end else begin
      state_r <= state_nxt;
      open_r  <= open_nxt;
      rows_r  <= rows_nxt;
    end
    line_r    <= line_nxt;
    final_r   <= final_nxt;
    col_r     <= col_nxt;
    rd_addr_r <= rd_addr_nxt;
  end

endmodule
